### hdl/mntg_pkg.sv
// shared constants, types and helpers for the midi note to gate converter
// no dependencies; imported by mntg_cellmap, mntg_engine and the top level
package mntg_pkg;

    localparam int CELLS    = 16;
    localparam int CHANNELS = 16;

    localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W  = (CELLS * CHANNELS > 1) ? $clog2(CELLS * CHANNELS) : 1;
    localparam int CMP_W   = CELL_W + 4;
    localparam int MASK_W  = 16;
    localparam int NOTE_W  = 7;
    localparam int PULSE_W = 16;
    localparam int CFG_W   = 16;

    localparam logic [2:0] FN_MIDI  = 3'd0;
    localparam logic [2:0] FN_TICK  = 3'd1;
    localparam logic [2:0] FN_READ  = 3'd2;
    localparam logic [2:0] FN_ARM   = 3'd3;
    localparam logic [2:0] FN_PANIC = 3'd4;

    localparam logic [3:0] ST_OFF = 4'h8;
    localparam logic [3:0] ST_ON  = 4'h9;

    localparam logic [1:0] CFG_VELOCITY_MODE = 2'd0;
    localparam logic [1:0] CFG_MPE_MODE      = 2'd1;
    localparam logic [1:0] CFG_MIN_PULSE     = 2'd2;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RESET = 16'd48;
    localparam logic [NOTE_W-1:0]  FULL_LEVEL      = 7'd127;
    localparam int                 BASE_NOTE       = 36;

    typedef enum logic [2:0] {
        OP_SCAN,
        OP_PRESS,
        OP_RELEASE,
        OP_TICK,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [3:0]        ch;
        logic              ch_ok;
        logic              all_ch;
        logic [3:0]        cell_sel;
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] vel;
        logic              report;
    } job_t;

    typedef struct packed {
        logic              arm;
        logic              capture;
        logic [3:0]        cell_sel;
        logic [NOTE_W-1:0] note;
    } learn_cmd_t;

    typedef struct packed {
        logic               gate;
        logic [PULSE_W-1:0] pulse;
        logic [NOTE_W-1:0]  vel;
    } entry_t;

    // drum grid: bottom row holds the lowest notes
    function automatic logic [NOTE_W-1:0] cell_note_init(input int idx);
        int n;
        n = BASE_NOTE + 12 - 4 * (idx / 4) + (idx % 4);
        return NOTE_W'(n & 127);
    endfunction

endpackage

### hdl/mntg_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module mntg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mntg_cellmap.sv
// note number held by each cell, learn arm and capture, note match vector
// depends on mntg_pkg
module mntg_cellmap (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mntg_pkg::learn_cmd_t              learn,
    input  logic [mntg_pkg::NOTE_W-1:0]       match_note,
    output logic [mntg_pkg::CELLS-1:0]        match_vec
);
    import mntg_pkg::*;

    logic [NOTE_W-1:0] note_reg [CELLS];
    logic              armed_reg;
    logic [3:0]        target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                note_reg[i] <= cell_note_init(i);
            end
            armed_reg  <= 1'b0;
            target_reg <= '0;
        end
        else
        begin
            if (learn.arm)
            begin
                armed_reg  <= 1'b1;
                target_reg <= learn.cell_sel;
            end
            else if (learn.capture && armed_reg)
            begin
                armed_reg <= 1'b0;
                for (int i = 0; i < CELLS; i++)
                begin
                    if (CMP_W'(target_reg) == CMP_W'(i))
                    begin
                        note_reg[i] <= learn.note;
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            match_vec[i] = (note_reg[i] == match_note);
        end
    end

endmodule

### hdl/mntg_engine.sv
// sweep engine: read-modify-write over the gate/pulse/velocity ram, result build
// depends on mntg_pkg and mntg_ram
module mntg_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  mntg_pkg::job_t                     job,
    input  logic                               velocity_mode,
    input  logic [mntg_pkg::PULSE_W-1:0]       min_pulse_ticks,
    input  logic [mntg_pkg::CELLS-1:0]         match_vec,
    output logic [mntg_pkg::NOTE_W-1:0]        job_note,
    output logic                               busy,
    output logic                               done,
    output logic [mntg_pkg::MASK_W-1:0]        gate_mask,
    output logic                               active,
    output logic [mntg_pkg::NOTE_W-1:0]        level
);
    import mntg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t              state_reg;
    job_t                job_reg;
    logic [CELL_W-1:0]   cell_cnt_reg;
    logic [CH_W-1:0]     chan_cnt_reg;
    logic                s1_valid_reg;
    logic                s1_last_reg;
    logic [CELL_W-1:0]   s1_cell_reg;
    logic [CH_W-1:0]     s1_chan_reg;
    logic [MASK_W-1:0]   mask_acc_reg;
    logic                act_acc_reg;
    logic [NOTE_W-1:0]   vel_acc_reg;
    logic                done_reg;
    logic [MASK_W-1:0]   gate_mask_reg;
    logic                active_reg;
    logic [NOTE_W-1:0]   level_reg;

    logic                span_all;
    logic                start_span_all;
    logic                cell_last;
    logic                chan_last;
    logic                issue_last;
    logic [ADDR_W-1:0]   raddr;
    logic [ADDR_W-1:0]   waddr;
    logic [$bits(entry_t)-1:0] rdata;
    entry_t              rd;
    entry_t              wr;
    logic                we;
    logic                hit;
    logic                act_now;
    logic                on_ch;
    logic [CMP_W-1:0]    cell_x;
    logic [MASK_W-1:0]   mask_next;
    logic                act_next;
    logic [NOTE_W-1:0]   vel_next;

    assign span_all = (job_reg.op == OP_CLEAR) || ((job_reg.op == OP_TICK) && job_reg.all_ch);
    assign start_span_all = (job.op == OP_CLEAR) || ((job.op == OP_TICK) && job.all_ch);
    assign cell_last  = (cell_cnt_reg == CELL_W'(CELLS - 1));
    assign chan_last  = (chan_cnt_reg == CH_W'(CHANNELS - 1));
    assign issue_last = cell_last && (!span_all || chan_last);

    assign raddr = ADDR_W'(cell_cnt_reg) * ADDR_W'(CHANNELS) + ADDR_W'(chan_cnt_reg);
    assign waddr = ADDR_W'(s1_cell_reg) * ADDR_W'(CHANNELS) + ADDR_W'(s1_chan_reg);

    mntg_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (CELLS * CHANNELS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    // modify stage: entry read last cycle is updated and written back, except in a scan
    always_comb
    begin
        rd  = entry_t'(rdata);
        wr  = rd;
        hit = match_vec[s1_cell_reg];
        unique case (job_reg.op)
            OP_PRESS:
            begin
                if (hit)
                begin
                    wr.gate  = 1'b1;
                    wr.pulse = min_pulse_ticks;
                    wr.vel   = job_reg.vel;
                end
            end
            OP_RELEASE:
            begin
                if (hit)
                begin
                    wr.gate = 1'b0;
                end
            end
            OP_TICK:
            begin
                if (rd.pulse != '0)
                begin
                    wr.pulse = rd.pulse - PULSE_W'(1);
                end
            end
            OP_CLEAR:
            begin
                wr = '0;
            end
            default:
            begin
                wr = rd;
            end
        endcase
        we      = s1_valid_reg && (job_reg.op != OP_SCAN);
        act_now = wr.gate || (wr.pulse != '0);
        cell_x  = CMP_W'(s1_cell_reg);
        on_ch   = s1_valid_reg && job_reg.ch_ok && (s1_chan_reg == job_reg.ch[CH_W-1:0]);

        mask_next = mask_acc_reg;
        act_next  = act_acc_reg;
        vel_next  = vel_acc_reg;
        if (on_ch && act_now && (cell_x < CMP_W'(MASK_W)))
        begin
            mask_next[cell_x[3:0]] = 1'b1;
        end
        if (on_ch && (cell_x == CMP_W'(job_reg.cell_sel)))
        begin
            act_next = act_now;
            vel_next = wr.vel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // power-up runs a clearing sweep with no result
            state_reg      <= ST_READ;
            job_reg        <= '{op: OP_CLEAR, default: '0};
            cell_cnt_reg   <= '0;
            chan_cnt_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            s1_cell_reg    <= '0;
            s1_chan_reg    <= '0;
            mask_acc_reg   <= '0;
            act_acc_reg    <= 1'b0;
            vel_acc_reg    <= '0;
            done_reg       <= 1'b0;
            gate_mask_reg  <= '0;
            active_reg     <= 1'b0;
            level_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;

            if (s1_valid_reg)
            begin
                mask_acc_reg <= mask_next;
                act_acc_reg  <= act_next;
                vel_acc_reg  <= vel_next;
                if (s1_last_reg)
                begin
                    done_reg      <= job_reg.report;
                    gate_mask_reg <= mask_next;
                    active_reg    <= act_next;
                    if (!act_next)
                    begin
                        level_reg <= '0;
                    end
                    else if (velocity_mode)
                    begin
                        level_reg <= vel_next;
                    end
                    else
                    begin
                        level_reg <= FULL_LEVEL;
                    end
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        job_reg      <= job;
                        cell_cnt_reg <= '0;
                        chan_cnt_reg <= start_span_all ? '0 : job.ch[CH_W-1:0];
                        mask_acc_reg <= '0;
                        act_acc_reg  <= 1'b0;
                        vel_acc_reg  <= '0;
                        state_reg    <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    s1_valid_reg <= 1'b1;
                    s1_last_reg  <= issue_last;
                    s1_cell_reg  <= cell_cnt_reg;
                    s1_chan_reg  <= chan_cnt_reg;
                    if (cell_last)
                    begin
                        cell_cnt_reg <= '0;
                        if (span_all)
                        begin
                            chan_cnt_reg <= chan_cnt_reg + CH_W'(1);
                        end
                    end
                    else
                    begin
                        cell_cnt_reg <= cell_cnt_reg + CELL_W'(1);
                    end
                    if (issue_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign job_note  = job_reg.note;
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign gate_mask = gate_mask_reg;
    assign active    = active_reg;
    assign level     = level_reg;

endmodule

### hdl/midi_note_to_gate_converter_unit.sv
// midi note to gate converter, top level: config registers, command decode
// depends on mntg_pkg, mntg_cellmap, mntg_engine (and mntg_ram below it)
// done pulses once the sweep has modified its last ram entry: one channel for a midi message,
// read, arm, or a tick outside mpe mode; every channel for a tick in mpe mode or a panic
// throughput: one ram entry per cycle in the sweep; a new command is taken only once busy drops
// reset: a clearing sweep runs with busy high; config writes are taken then
// results cannot be stalled: each one is shown for a single cycle with done
module midi_note_to_gate_converter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    func,
    input  logic [3:0]                    status,
    input  logic [3:0]                    channel,
    input  logic [6:0]                    note,
    input  logic [6:0]                    value,
    input  logic [3:0]                    cell_req,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [mntg_pkg::CFG_W-1:0]    cfg_data,
    output logic                          done,
    output logic [15:0]                   gate_mask,
    output logic                          active,
    output logic [6:0]                    level
);
    import mntg_pkg::*;

    logic               velocity_mode_reg;
    logic               mpe_mode_reg;
    logic [PULSE_W-1:0] min_pulse_ticks_reg;

    logic               accept;
    logic [3:0]         ch_eff;
    logic               ch_ok;
    logic               cell_ok;
    op_t                op;
    job_t               job;
    learn_cmd_t         learn;
    logic [CELLS-1:0]   match_vec;
    logic [NOTE_W-1:0]  job_note;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            velocity_mode_reg   <= 1'b0;
            mpe_mode_reg        <= 1'b0;
            min_pulse_ticks_reg <= MIN_PULSE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VELOCITY_MODE: velocity_mode_reg   <= cfg_data[0];
                CFG_MPE_MODE:      mpe_mode_reg        <= cfg_data[0];
                CFG_MIN_PULSE:     min_pulse_ticks_reg <= cfg_data[PULSE_W-1:0];
                default:           ;
            endcase
        end
    end

    assign accept  = start && !busy;
    assign ch_eff  = mpe_mode_reg ? channel : 4'd0;
    assign ch_ok   = ({1'b0, ch_eff} < 5'(CHANNELS));
    assign cell_ok = (7'(cell_req) < 7'(CELLS));

    always_comb
    begin
        op = OP_SCAN;
        unique case (func)
            FN_MIDI:
            begin
                if (ch_ok)
                begin
                    if ((status == ST_ON) && (value != '0))
                    begin
                        op = OP_PRESS;
                    end
                    else if ((status == ST_ON) || (status == ST_OFF))
                    begin
                        op = OP_RELEASE;
                    end
                end
            end
            FN_TICK:  op = OP_TICK;
            FN_PANIC: op = OP_CLEAR;
            default:  op = OP_SCAN;
        endcase

        job.op       = op;
        job.ch       = ch_ok ? ch_eff : 4'd0;
        job.ch_ok    = ch_ok;
        job.all_ch   = mpe_mode_reg;
        job.cell_sel = cell_req;
        job.note     = note;
        job.vel      = value;
        job.report   = 1'b1;

        learn.arm      = accept && (func == FN_ARM) && cell_ok;
        learn.capture  = accept && (op == OP_PRESS);
        learn.cell_sel = cell_req;
        learn.note     = note;
    end

    mntg_cellmap u_cellmap (
        .clk        (clk),
        .rst_n      (rst_n),
        .learn      (learn),
        .match_note (job_note),
        .match_vec  (match_vec)
    );

    mntg_engine u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (accept),
        .job             (job),
        .velocity_mode   (velocity_mode_reg),
        .min_pulse_ticks (min_pulse_ticks_reg),
        .match_vec       (match_vec),
        .job_note        (job_note),
        .busy            (busy),
        .done            (done),
        .gate_mask       (gate_mask),
        .active          (active),
        .level           (level)
    );

endmodule

### hdl/mntg_checker.sv
// port-level checks for the midi note to gate converter, bound to the top level
// no package dependency; watches only the handshake and result ports
module mntg_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          done,
    input  logic                          active,
    input  logic [6:0]                    level
);

    // a result beat only appears once the sweep has finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result beat while sweep still running");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start a sweep");

    a_level_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !active) |-> (level == 7'd0))
        else $error("nonzero level on an inactive output");

endmodule

bind midi_note_to_gate_converter_unit mntg_checker u_mntg_checker (.*);
